[rtl/rbst_pkg.sv]
// ----------------------------------------------------------------------------
// rbst_pkg
// Shared types and register codes for the ray versus box slab test.
// ----------------------------------------------------------------------------
`default_nettype none

package rbst_pkg;

  // Width of a register index taken from the configuration address
  localparam int REG_IDX_W = 3;

  // Configuration register codes, in address order
  typedef enum logic [REG_IDX_W-1:0] {
    REG_MIN_X = 3'd0,
    REG_MIN_Y = 3'd1,
    REG_MIN_Z = 3'd2,
    REG_MAX_X = 3'd3,
    REG_MAX_Y = 3'd4,
    REG_MAX_Z = 3'd5
  } reg_idx_t;

  // Load enables for the three stages inside a slab lane
  typedef struct packed {
    logic s1;  // difference stage
    logic s2;  // product stage
    logic s3;  // shift and clamp stage
  } stage_en_t;

endpackage

`default_nettype wire

[rtl/rbst_if.sv]
// ----------------------------------------------------------------------------
// rbst_if
// Valid/ready channels: ray requests in, hit results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface rbst_ray_if #(
  parameter int COORD_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] origin_x;
  logic signed [COORD_WIDTH-1:0] origin_y;
  logic signed [COORD_WIDTH-1:0] origin_z;
  logic signed [COORD_WIDTH-1:0] recip_x;
  logic signed [COORD_WIDTH-1:0] recip_y;
  logic signed [COORD_WIDTH-1:0] recip_z;
  logic signed [COORD_WIDTH-1:0] t_near;
  logic signed [COORD_WIDTH-1:0] t_far;

  modport source (
    output valid, origin_x, origin_y, origin_z,
    output recip_x, recip_y, recip_z, t_near, t_far,
    input  ready
  );
  modport sink (
    input  valid, origin_x, origin_y, origin_z,
    input  recip_x, recip_y, recip_z, t_near, t_far,
    output ready
  );
endinterface

interface rbst_hit_if;
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, hit, input ready);
  modport sink (input valid, hit, output ready);
endinterface

`default_nettype wire

[rtl/ray_box_slab_test.sv]
// An accepted ray reaches its hit result through six register stages.
// Throughput: one ray per cycle while the output is not back-pressured; each
// axis has its own lane with two multipliers, so nothing is shared between rays in flight.
// Every stage has its own valid bit and loads when it is empty or the stage
// after it can take its contents, so bubbles close up under output back-pressure.
// Reset (rst, synchronous): clears all valid bits and the six box bounds.
// ----------------------------------------------------------------------------
// ray_box_slab_test
// Ray versus axis-aligned box test by the slab method, with the box held in
// APB-writable registers and six pipeline stages.
// ----------------------------------------------------------------------------
`default_nettype none

module ray_box_slab_test #(
  parameter int   COORD_WIDTH = 32,
  parameter int   FRAC_BITS   = 16,
  localparam int  APB_W       = (COORD_WIDTH > 32) ? 64 : 32,
  localparam int  ADDR_W      = (COORD_WIDTH > 32) ? 6 : 5
) (
  input  wire logic              clk,
  input  wire logic              rst,
  rbst_ray_if.sink               ray,
  rbst_hit_if.source             result,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [APB_W-1:0]  pwdata,
  output logic [APB_W-1:0]       prdata,
  output logic                   pready
);
  import rbst_pkg::*;

  localparam int W        = COORD_WIDTH;
  localparam int ADDR_LSB = ADDR_W - REG_IDX_W;

  // ------------------------------------------------------------------
  // Configuration registers
  // ------------------------------------------------------------------
  logic signed [W-1:0] box_min_x, box_min_y, box_min_z;
  logic signed [W-1:0] box_max_x, box_max_y, box_max_z;
  logic                cfg_wr;
  reg_idx_t            cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:ADDR_LSB]);

  always_ff @(posedge clk) begin
    if (rst) begin
      box_min_x <= '0;
      box_min_y <= '0;
      box_min_z <= '0;
      box_max_x <= '0;
      box_max_y <= '0;
      box_max_z <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_MIN_X: box_min_x <= pwdata[W-1:0];
        REG_MIN_Y: box_min_y <= pwdata[W-1:0];
        REG_MIN_Z: box_min_z <= pwdata[W-1:0];
        REG_MAX_X: box_max_x <= pwdata[W-1:0];
        REG_MAX_Y: box_max_y <= pwdata[W-1:0];
        REG_MAX_Z: box_max_z <= pwdata[W-1:0];
        default: ;
      endcase
    end
  end

  // Read-back, zero-extended
  always_comb begin
    prdata = '0;
    case (cfg_idx)
      REG_MIN_X: prdata[W-1:0] = box_min_x;
      REG_MIN_Y: prdata[W-1:0] = box_min_y;
      REG_MIN_Z: prdata[W-1:0] = box_min_z;
      REG_MAX_X: prdata[W-1:0] = box_max_x;
      REG_MAX_Y: prdata[W-1:0] = box_max_y;
      REG_MAX_Z: prdata[W-1:0] = box_max_z;
      default:   prdata = '0;
    endcase
  end

  // ------------------------------------------------------------------
  // Stage valids and per-stage ready chain
  // ------------------------------------------------------------------
  logic s1_valid, s2_valid, s3_valid, s4_valid, s5_valid, s6_valid;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;
  stage_en_t lane_en;

  assign rdy6 = !s6_valid || result.ready;
  assign rdy5 = !s5_valid || rdy6;
  assign rdy4 = !s4_valid || rdy5;
  assign rdy3 = !s3_valid || rdy4;
  assign rdy2 = !s2_valid || rdy3;
  assign rdy1 = !s1_valid || rdy2;

  assign ray.ready = rdy1;
  assign lane_en   = {rdy1, rdy2, rdy3};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
      s6_valid <= 1'b0;
    end else begin
      if (rdy1) s1_valid <= ray.valid;
      if (rdy2) s2_valid <= s1_valid;
      if (rdy3) s3_valid <= s2_valid;
      if (rdy4) s4_valid <= s3_valid;
      if (rdy5) s5_valid <= s4_valid;
      if (rdy6) s6_valid <= s5_valid;
    end
  end

  // ------------------------------------------------------------------
  // Stages 1-3: one slab lane per axis
  // ------------------------------------------------------------------
  logic signed [W-1:0] x_in, x_out, y_in, y_out, z_in, z_out;

  rbst_slab_lane #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_lane_x (
    .clk      (clk),
    .en       (lane_en),
    .origin   (ray.origin_x),
    .inv_dir  (ray.recip_x),
    .bound_lo (box_min_x),
    .bound_hi (box_max_x),
    .t_entry  (x_in),
    .t_exit   (x_out)
  );

  rbst_slab_lane #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_lane_y (
    .clk      (clk),
    .en       (lane_en),
    .origin   (ray.origin_y),
    .inv_dir  (ray.recip_y),
    .bound_lo (box_min_y),
    .bound_hi (box_max_y),
    .t_entry  (y_in),
    .t_exit   (y_out)
  );

  rbst_slab_lane #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_lane_z (
    .clk      (clk),
    .en       (lane_en),
    .origin   (ray.origin_z),
    .inv_dir  (ray.recip_z),
    .bound_lo (box_min_z),
    .bound_hi (box_max_z),
    .t_entry  (z_in),
    .t_exit   (z_out)
  );

  // Ray interval travels alongside the lanes
  logic signed [W-1:0] tn1, tn2, tn3, tn4, tn5;
  logic signed [W-1:0] tf1, tf2, tf3, tf4, tf5;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      tn1 <= ray.t_near;
      tf1 <= ray.t_far;
    end
    if (rdy2) begin
      tn2 <= tn1;
      tf2 <= tf1;
    end
    if (rdy3) begin
      tn3 <= tn2;
      tf3 <= tf2;
    end
    if (rdy4) begin
      tn4 <= tn3;
      tf4 <= tf3;
    end
    if (rdy5) begin
      tn5 <= tn4;
      tf5 <= tf4;
    end
  end

  // ------------------------------------------------------------------
  // Stage 4: merge x and y slabs, early reject on no overlap
  // ------------------------------------------------------------------
  logic signed [W-1:0] tin4, tout4, tin4_next, tout4_next;
  logic signed [W-1:0] z_in4, z_out4;
  logic                miss4, miss4_next;

  always_comb begin
    miss4_next = (x_in > y_out) || (y_in > x_out);
    tin4_next  = (y_in > x_in) ? y_in : x_in;
    tout4_next = (y_out < x_out) ? y_out : x_out;
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      tin4   <= tin4_next;
      tout4  <= tout4_next;
      miss4  <= miss4_next;
      z_in4  <= z_in;
      z_out4 <= z_out;
    end
  end

  // ------------------------------------------------------------------
  // Stage 5: merge z slab
  // ------------------------------------------------------------------
  logic signed [W-1:0] tin5, tout5, tin5_next, tout5_next;
  logic                miss5, miss5_next;

  always_comb begin
    miss5_next = miss4 || (tin4 > z_out4) || (z_in4 > tout4);
    tin5_next  = (z_in4 > tin4) ? z_in4 : tin4;
    tout5_next = (z_out4 < tout4) ? z_out4 : tout4;
  end

  always_ff @(posedge clk) begin
    if (rdy5) begin
      tin5  <= tin5_next;
      tout5 <= tout5_next;
      miss5 <= miss5_next;
    end
  end

  // ------------------------------------------------------------------
  // Stage 6: strict compare against the ray interval; output register
  // ------------------------------------------------------------------
  logic hit, hit_next;

  assign hit_next = !miss5 && (tin5 < tf5) && (tout5 > tn5);

  always_ff @(posedge clk) begin
    if (rdy6) begin
      hit <= hit_next;
    end
  end

  assign result.valid = s6_valid;
  assign result.hit   = hit;

`ifndef SYNTHESIS
  // A slab miss never turns into a hit at the output
  a_miss_no_hit: assert property (@(posedge clk) disable iff (rst)
    (rdy6 && s5_valid && miss5) |=> !result.hit)
    else $error("rejected ray reported as hit");

  // A stalled merge stage keeps its request and interval
  a_stage4_hold: assert property (@(posedge clk) disable iff (rst)
    (s4_valid && !rdy4) |=> (s4_valid && $stable(tin4) && $stable(tout4)))
    else $error("stage 4 lost or changed a stalled request");

  // Input is taken under output back-pressure only if a bubble exists
  a_bubble_accept: assert property (@(posedge clk) disable iff (rst)
    (s6_valid && !result.ready && ray.ready) |->
      (!s1_valid || !s2_valid || !s3_valid || !s4_valid || !s5_valid))
    else $error("request accepted into a full pipeline");

  // No result right after reset
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !result.valid)
    else $error("result valid right after reset");
`endif

endmodule

`default_nettype wire

[rtl/rbst_slab_lane.sv]
// ----------------------------------------------------------------------------
// rbst_slab_lane
// One axis of the slab test: picks near/far bounds by the sign of the
// inverse direction, then computes (bound - origin) * inv_dir for both,
// floored to the fixed-point grid and clamped. Three register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module rbst_slab_lane #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  wire logic                          clk,
  input  wire rbst_pkg::stage_en_t           en,
  input  wire logic signed [COORD_WIDTH-1:0] origin,
  input  wire logic signed [COORD_WIDTH-1:0] inv_dir,
  input  wire logic signed [COORD_WIDTH-1:0] bound_lo,
  input  wire logic signed [COORD_WIDTH-1:0] bound_hi,
  output logic signed [COORD_WIDTH-1:0]      t_entry,
  output logic signed [COORD_WIDTH-1:0]      t_exit
);
  import rbst_pkg::*;

  localparam int W  = COORD_WIDTH;
  localparam int DW = W + 1;           // exact difference
  localparam int PW = DW + W;          // exact product
  localparam int SW = PW - FRAC_BITS;  // product after the fraction shift

  localparam logic signed [W-1:0] CMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] CMIN = {1'b1, {(W-1){1'b0}}};

  // Floor shift then clamp to the coordinate range
  function automatic logic signed [W-1:0] clamp(input logic signed [PW-1:0] p);
    logic [SW-1:0] q;
    logic          in_range;
    q        = p[PW-1:FRAC_BITS];
    in_range = (&q[SW-1:W-1]) || !(|q[SW-1:W-1]);
    if (in_range) begin
      clamp = q[W-1:0];
    end else begin
      clamp = q[SW-1] ? CMIN : CMAX;
    end
  endfunction

  // Stage 1: bound select and exact differences
  logic signed [W-1:0]  near_b, far_b;
  logic signed [DW-1:0] diff_n, diff_f;
  logic signed [W-1:0]  inv_s1;
  logic                 inf_s1;

  always_comb begin
    near_b = inv_dir[W-1] ? bound_hi : bound_lo;
    far_b  = inv_dir[W-1] ? bound_lo : bound_hi;
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      diff_n <= $signed({near_b[W-1], near_b}) - $signed({origin[W-1], origin});
      diff_f <= $signed({far_b[W-1], far_b}) - $signed({origin[W-1], origin});
      inv_s1 <= inv_dir;
      inf_s1 <= (inv_dir == CMAX) || (inv_dir == CMIN);
    end
  end

  // Stage 2: full-width products, signs kept for the infinite case
  logic signed [PW-1:0] prod_n, prod_f;
  logic                 inf_s2, inv_neg_s2, dn_neg_s2, df_neg_s2;

  always_ff @(posedge clk) begin
    if (en.s2) begin
      prod_n     <= PW'(diff_n) * PW'(inv_s1);
      prod_f     <= PW'(diff_f) * PW'(inv_s1);
      inf_s2     <= inf_s1;
      inv_neg_s2 <= inv_s1[W-1];
      dn_neg_s2  <= diff_n[DW-1];
      df_neg_s2  <= diff_f[DW-1];
    end
  end

  // Stage 3: shift, clamp; an infinite inverse direction goes to an extreme
  always_ff @(posedge clk) begin
    if (en.s3) begin
      if (inf_s2) begin
        t_entry <= (dn_neg_s2 ^ inv_neg_s2) ? CMIN : CMAX;
        t_exit  <= (df_neg_s2 ^ inv_neg_s2) ? CMIN : CMAX;
      end else begin
        t_entry <= clamp(prod_n);
        t_exit  <= clamp(prod_f);
      end
    end
  end

endmodule

`default_nettype wire

[verif/ray_box_slab_test_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ray_box_slab_test_test
// Self-checking bench for the ray versus box slab test. The box is loaded over
// APB between phases. Rays are streamed through the valid/ready channel,
// first directed corner cases, then rays aimed at or near the box mixed with
// raw noise. Every accepted request is run through a local fixed-point slab
// predictor, and each hit result is checked in order against its prediction.
// ----------------------------------------------------------------------------
module ray_box_slab_test_test;
  import rbst_pkg::*;

  localparam int ONE            = 1 << 16;
  localparam int FB             = 16;
  localparam int NUM_PHASES     = 9;
  localparam int RAYS_PER_PHASE = 215;
  localparam int STALL_AT       = 400;
  localparam int STALL_LEN      = 150;
  localparam int DRAIN_CYCLES   = 12;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int ORG_SPAN       = 16 * ONE;

  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
  localparam longint L_MAX = 64'sd2147483647;
  localparam longint L_MIN = -64'sd2147483648;

  typedef struct packed {
    logic [2:0][31:0] org;
    logic [2:0][31:0] inv;
    logic [31:0]      t_near;
    logic [31:0]      t_far;
  } ray_req_t;

  // Clock, reset and APB drive
  logic        clk     = 1'b0;
  logic        rst     = 1'b1;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [4:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  wire  [31:0] prdata;
  wire         pready;

  // Channel drive
  logic     ray_valid   = 1'b0;
  ray_req_t ray_payload = '0;
  logic     hit_ready   = 1'b0;
  logic     ray_taken   = 1'b0;
  logic     calm        = 1'b0;
  int       stall_left  = 0;
  logic     stall_done  = 1'b0;

  // Bench bookkeeping
  logic [31:0] box_reg [6];
  ray_req_t    ray_backlog [$];
  logic        hit_expect [$];
  int          rays_accepted = 0;
  int          mismatches    = 0;
  int          cycles        = 0;

  rbst_ray_if #(.COORD_WIDTH(32)) ray_ch ();
  rbst_hit_if                     hit_ch ();

  assign ray_ch.valid    = ray_valid;
  assign ray_ch.origin_x = ray_payload.org[0];
  assign ray_ch.origin_y = ray_payload.org[1];
  assign ray_ch.origin_z = ray_payload.org[2];
  assign ray_ch.recip_x  = ray_payload.inv[0];
  assign ray_ch.recip_y  = ray_payload.inv[1];
  assign ray_ch.recip_z  = ray_payload.inv[2];
  assign ray_ch.t_near   = ray_payload.t_near;
  assign ray_ch.t_far    = ray_payload.t_far;
  assign hit_ch.ready    = hit_ready;

  ray_box_slab_test #(
    .COORD_WIDTH(32),
    .FRAC_BITS  (FB)
  ) u_dut (
    .clk    (clk),
    .rst    (rst),
    .ray    (ray_ch),
    .result (hit_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Slab entry/exit time: (bound - origin) * inv_dir, floored and saturated.
  // An extreme inv_dir is infinity, signed by the product; zero diff counts
  // as positive.
  function automatic logic signed [31:0] slab_time(logic signed [32:0] diff,
                                                   logic signed [31:0] inv);
    logic signed [95:0] prod;
    logic               neg;
    neg = (diff < 0) != (inv < 0);
    if (inv == Q_MAX || inv == Q_MIN)
      return neg ? Q_MIN : Q_MAX;
    prod = diff * inv;
    prod = prod >>> FB;
    if (prod > Q_MAX)
      return Q_MAX;
    if (prod < Q_MIN)
      return Q_MIN;
    return prod[31:0];
  endfunction

  // Hit decision for one ray against the current box
  function automatic logic slab_hit(ray_req_t r);
    logic signed [31:0] lo_b, hi_b, org, inv, near_b, far_b;
    logic signed [31:0] s_in, s_out, t_in, t_out;
    logic signed [32:0] d_in, d_out;
    logic               ok;
    int                 a;
    ok    = 1'b1;
    t_in  = '0;
    t_out = '0;
    for (a = 0; a < 3; a++) begin
      lo_b   = box_reg[int'(REG_MIN_X) + a];
      hi_b   = box_reg[int'(REG_MAX_X) + a];
      org    = r.org[a];
      inv    = r.inv[a];
      near_b = (inv < 0) ? hi_b : lo_b;
      far_b  = (inv < 0) ? lo_b : hi_b;
      d_in   = near_b - org;
      d_out  = far_b - org;
      s_in   = slab_time(d_in, inv);
      s_out  = slab_time(d_out, inv);
      if (a == 0) begin
        t_in  = s_in;
        t_out = s_out;
      end else if (ok) begin
        // early out when the running interval and this slab do not overlap
        if (t_in > s_out || s_in > t_out) begin
          ok = 1'b0;
        end else begin
          if (s_in > t_in) t_in = s_in;
          if (s_out < t_out) t_out = s_out;
        end
      end
    end
    if (ok)
      ok = (t_in < $signed(r.t_far)) && (t_out > $signed(r.t_near));
    return ok;
  endfunction

  function automatic longint sat32(longint v);
    if (v > L_MAX) return L_MAX;
    if (v < L_MIN) return L_MIN;
    return v;
  endfunction

  // Random words half the time, else the extremes, zero or unit values
  function automatic logic [31:0] wild_word();
    case ($urandom_range(0, 9))
      0:       return Q_MAX;
      1:       return Q_MIN;
      2:       return '0;
      3:       return $urandom_range(0, 1) ? 32'(ONE) : 32'(-ONE);
      4:       return $urandom_range(0, 1) ? 32'sd1 : -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  function automatic ray_req_t noise_ray();
    ray_req_t r;
    int       a;
    for (a = 0; a < 3; a++) begin
      r.org[a] = wild_word();
      r.inv[a] = wild_word();
    end
    r.t_near = wild_word();
    r.t_far  = wild_word();
    return r;
  endfunction

  // Ray from a random origin toward a point in or just beside the box
  function automatic ray_req_t aimed_ray();
    ray_req_t r;
    longint   lo, hi, span, tgt, org, dir, q, tmp;
    int       a;
    for (a = 0; a < 3; a++) begin
      lo   = longint'($signed(box_reg[int'(REG_MIN_X) + a]));
      hi   = longint'($signed(box_reg[int'(REG_MAX_X) + a]));
      span = hi - lo;
      tgt  = lo + (span * longint'($urandom_range(0, 1024))) / 1024;
      if ($urandom_range(0, 3) == 0)
        tgt += ($urandom_range(0, 1) ? 1 : -1) * longint'($urandom_range(0, 4 * ONE));
      org = sat32(tgt + longint'($urandom_range(0, 2 * ORG_SPAN)) - ORG_SPAN);
      dir = tgt - org;
      if (dir == 0 || $urandom_range(0, 9) == 0)
        q = $urandom_range(0, 1) ? L_MAX : L_MIN;
      else
        q = sat32(64'sd4294967296 / dir);
      r.org[a] = org[31:0];
      r.inv[a] = q[31:0];
    end
    case ($urandom_range(0, 3))
      0, 1:    tmp = 0;
      2:       tmp = longint'($urandom_range(0, 2 * ONE)) - ONE;
      default: tmp = longint'($signed(wild_word()));
    endcase
    r.t_near = tmp[31:0];
    case ($urandom_range(0, 3))
      0, 1:    tmp = L_MAX;
      2:       tmp = longint'($urandom_range(0, 3 * ONE));
      default: tmp = longint'($signed(wild_word()));
    endcase
    r.t_far = tmp[31:0];
    return r;
  endfunction

  function automatic ray_req_t mk_ray(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                                      logic [31:0] ix, logic [31:0] iy, logic [31:0] iz,
                                      logic [31:0] tn, logic [31:0] tf);
    ray_req_t r;
    r.org    = {oz, oy, ox};
    r.inv    = {iz, iy, ix};
    r.t_near = tn;
    r.t_far  = tf;
    return r;
  endfunction

  // APB write: setup then access, register lands when pready is seen
  task automatic apb_write(reg_idx_t idx, logic [31:0] value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    box_reg[idx] = value;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic load_box(logic [2:0][31:0] mn, logic [2:0][31:0] mx);
    int a;
    for (a = 0; a < 3; a++) begin
      apb_write(reg_idx_t'(int'(REG_MIN_X) + a), mn[a]);
      apb_write(reg_idx_t'(int'(REG_MAX_X) + a), mx[a]);
    end
    @(posedge clk);
  endtask

  task automatic log_mismatch(string what, logic want, logic got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t hit check (%s): expected %0b, got %0b", $realtime, what, want, got);
  endtask

  // Request acceptance, seen at the rising edge
  always @(posedge clk) begin
    ray_taken = !rst && ray_valid && ray_ch.ready;
    if (ray_taken)
      rays_accepted++;
  end

  // Request driver: predict for the request just taken, then offer the next
  always @(negedge clk) begin
    if (ray_taken) begin
      hit_expect.push_back(slab_hit(ray_payload));
      void'(ray_backlog.pop_front());
    end
    if (rst) begin
      ray_valid <= 1'b0;
    end else if (!ray_valid || ray_taken) begin
      if (ray_backlog.size() != 0 && (calm || $urandom_range(0, 99) >= 13)) begin
        ray_valid   <= 1'b1;
        ray_payload <= ray_backlog[0];
      end else begin
        ray_valid <= 1'b0;
      end
    end
  end

  // Result ready: random idling plus one long hold to back the pipe up
  always @(negedge clk) begin
    if (rst) begin
      hit_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      hit_ready  <= 1'b0;
    end else if (!stall_done && rays_accepted >= STALL_AT) begin
      stall_left <= STALL_LEN;
      stall_done <= 1'b1;
      hit_ready  <= 1'b0;
    end else begin
      hit_ready <= calm || ($urandom_range(0, 99) >= 13);
    end
  end

  // Result monitor
  always @(posedge clk) begin
    logic want;
    if (!rst && hit_ch.valid && hit_ready) begin
      if (hit_expect.size() == 0) begin
        log_mismatch("unexpected", 1'bx, hit_ch.hit);
      end else begin
        want = hit_expect.pop_front();
        if (hit_ch.hit !== want)
          log_mismatch("value", want, hit_ch.hit);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Phase sequencer: box setting, stimulus, drain
  initial begin
    logic [2:0][31:0] mn, mx;
    int               p, n, a;
    for (a = 0; a < 6; a++)
      box_reg[a] = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (p = 0; p < NUM_PHASES; p++) begin
      calm = (p == 4);
      // phase 0 runs on the reset box
      if (p > 0) begin
        for (a = 0; a < 3; a++) begin
          case (p)
            1: begin mn[a] = -ONE; mx[a] = ONE; end
            2: begin mn[a] = Q_MIN; mx[a] = Q_MAX; end
            3: begin mn[a] = Q_MAX; mx[a] = Q_MIN; end
            4: begin
              mn[a] = $urandom_range(0, 8 * ONE) - 4 * ONE;
              mx[a] = mn[a];
            end
            5, 6: begin
              mn[a] = $urandom_range(0, 64 * ONE) - 32 * ONE;
              mx[a] = mn[a] + $urandom_range(0, 16 * ONE);
            end
            7: begin
              mn[a] = $urandom_range(0, 64 * ONE) - 32 * ONE;
              mx[a] = mn[a] - $urandom_range(1, 16 * ONE);
            end
            default: begin mn[a] = $urandom; mx[a] = $urandom; end
          endcase
        end
        load_box(mn, mx);
      end
      @(posedge clk);

      // directed corners on the unit box
      if (p == 1) begin
        ray_backlog.push_back(mk_ray(-4*ONE, ONE/4, ONE/4, ONE, Q_MAX, Q_MAX, 0, Q_MAX));
        // entry equal to t_far, then exit equal to t_near: both miss
        ray_backlog.push_back(mk_ray(-4*ONE, ONE/4, ONE/4, ONE, Q_MAX, Q_MAX, 0, 3*ONE));
        ray_backlog.push_back(mk_ray(-4*ONE, ONE/4, ONE/4, ONE, Q_MAX, Q_MAX, 5*ONE, Q_MAX));
        // negative direction takes the upper bound as near
        ray_backlog.push_back(mk_ray(4*ONE, ONE/4, ONE/4, -ONE, Q_MAX, Q_MAX, 0, Q_MAX));
        // origin on a bound with infinite inverse direction
        ray_backlog.push_back(mk_ray(-4*ONE, -ONE, ONE/4, ONE, Q_MIN, Q_MAX, 0, Q_MAX));
        ray_backlog.push_back(mk_ray(-4*ONE, ONE, ONE/4, ONE, Q_MAX, Q_MAX, 0, Q_MAX));
        // early reject after y, then after z
        ray_backlog.push_back(mk_ray(-4*ONE, 3*ONE, 0, ONE, Q_MAX, Q_MAX, 0, Q_MAX));
        ray_backlog.push_back(mk_ray(-4*ONE, 0, 3*ONE, ONE, Q_MAX, Q_MAX, 0, Q_MAX));
        // zero inverse direction on x
        ray_backlog.push_back(mk_ray(0, ONE/4, ONE/4, 0, Q_MAX, Q_MIN, -ONE, ONE));
        // field extremes
        ray_backlog.push_back(mk_ray(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MAX));
        ray_backlog.push_back(mk_ray(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MIN));
        ray_backlog.push_back(mk_ray(Q_MIN, Q_MAX, 0, -1, -1, -1, Q_MIN, Q_MAX));
        ray_backlog.push_back(mk_ray(0, 0, 0, 1, -1, 1, -ONE, ONE));
        // empty interval
        ray_backlog.push_back(mk_ray(-4*ONE, 0, 0, ONE, Q_MAX, Q_MAX, 2*ONE, ONE));
        // product saturation just below infinity
        ray_backlog.push_back(mk_ray(Q_MIN, Q_MIN, Q_MIN, 32'sh7FFF_FFFE, 32'sh8000_0001,
                                     32'sh7FFF_FFFE, Q_MIN, Q_MAX));
        // diagonal ray with equal entries on all axes
        ray_backlog.push_back(mk_ray(-2*ONE, -2*ONE, -2*ONE, ONE, ONE, ONE, 0, Q_MAX));
      end

      for (n = 0; n < RAYS_PER_PHASE; n++)
        ray_backlog.push_back(($urandom_range(0, 9) < 7) ? aimed_ray() : noise_ray());

      // wait until every request of the phase is sent and every result is back
      while (ray_backlog.size() != 0 || hit_expect.size() != 0)
        @(posedge clk);
      repeat (DRAIN_CYCLES) @(posedge clk);
    end

    if (mismatches == 0 && hit_expect.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
